/* rtl/core/magnetometer_hard_iron_heading_defines.svh */
// Assertion macros shared by the compass heading RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef MAGNETOMETER_HARD_IRON_HEADING_DEFINES_SVH
`define MAGNETOMETER_HARD_IRON_HEADING_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define MHH_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define MHH_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

/* rtl/core/mhh_pkg.sv */
// Package for the hard-iron corrected compass: widths, constants, tables.
// Depends on nothing; imported by the interfaces and the top level.
`default_nettype none
package mhh_pkg;

    localparam int RAW_W        = 16;
    localparam int GAIN_W       = 11;
    localparam int FIELD_W      = 27;
    localparam int SUM_W        = 28;
    localparam int WIDE_W       = 32;
    localparam int ANG_W        = 29;
    localparam int ANG_FRAC     = 12;
    localparam int HEAD_W       = 15;
    localparam int CFG_W        = 3;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int RUN_STEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int STEP_W       = 5;
    localparam int MCNT_W       = 4;

    localparam logic [CFG_W-1:0]          GAIN_RESET    = 3'd4;
    localparam logic signed [FIELD_W-1:0] RESET_EXTREME = 27'sd1024000;
    localparam logic signed [ANG_W-1:0]   ANG_HALF      = 29'sd47185920;
    localparam logic signed [ANG_W-1:0]   ANG_FULL      = 29'sd94371840;
    localparam logic signed [ANG_W-1:0]   ANG_RND       = 29'sd2048;
    localparam logic [HEAD_W+1:0]         HEAD_FULL     = 17'd23040;

    // Q8 gain in 1/256 milligauss per count.
    function automatic logic [GAIN_W-1:0] gain_q8(input logic [CFG_W-1:0] idx);
        logic [GAIN_W-1:0] g;
        case (idx)
            3'd0: g = 11'd187;
            3'd1: g = 11'd236;
            3'd2: g = 11'd312;
            3'd3: g = 11'd389;
            3'd4: g = 11'd581;
            3'd5: g = 11'd655;
            3'd6: g = 11'd776;
            3'd7: g = 11'd1114;
            default: g = 11'd581;
        endcase
        return g;
    endfunction

    // Arctangent of 2^-i in 1/262144 degree.
    function automatic logic signed [ANG_W-1:0] atan_tab(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] a;
        case (i)
            5'd0:  a = 29'sd11796480;
            5'd1:  a = 29'sd6963869;
            5'd2:  a = 29'sd3679517;
            5'd3:  a = 29'sd1867780;
            5'd4:  a = 29'sd937515;
            5'd5:  a = 29'sd469214;
            5'd6:  a = 29'sd234664;
            5'd7:  a = 29'sd117339;
            5'd8:  a = 29'sd58671;
            5'd9:  a = 29'sd29335;
            5'd10: a = 29'sd14668;
            5'd11: a = 29'sd7334;
            5'd12: a = 29'sd3667;
            5'd13: a = 29'sd1833;
            5'd14: a = 29'sd917;
            5'd15: a = 29'sd458;
            5'd16: a = 29'sd229;
            5'd17: a = 29'sd115;
            5'd18: a = 29'sd57;
            5'd19: a = 29'sd29;
            5'd20: a = 29'sd14;
            5'd21: a = 29'sd7;
            5'd22: a = 29'sd4;
            5'd23: a = 29'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/mhh_in_if.sv */
// Request channel carrying one raw three-axis sample.
// Depends on mhh_pkg for field widths.
`default_nettype none
interface mhh_in_if import mhh_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;

    modport source (output valid, raw_x, raw_y, raw_z, input ready);
    modport sink   (input valid, raw_x, raw_y, raw_z, output ready);
endinterface
`default_nettype wire

/* rtl/core/mhh_out_if.sv */
// Result channel carrying corrected field and heading.
// Depends on mhh_pkg for field widths.
`default_nettype none
interface mhh_out_if import mhh_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] field_x;
    logic signed [FIELD_W-1:0] field_y;
    logic signed [FIELD_W-1:0] field_z;
    logic [HEAD_W-1:0]         heading;

    modport source (output valid, field_x, field_y, field_z, heading, input ready);
    modport sink   (input valid, field_x, field_y, field_z, heading, output ready);
endinterface
`default_nettype wire

/* rtl/core/magnetometer_hard_iron_heading.sv */
// Top level of the hard-iron corrected compass with CORDIC heading.
// Depends on mhh_pkg, mhh_in_if, mhh_out_if and the assertion macro header.
`default_nettype none
`include "magnetometer_hard_iron_heading_defines.svh"

// One request is processed at a time. After acceptance it passes through a
// bit-serial gain multiply (one gain bit per cycle for all three axes), the
// extreme update, midpoint subtraction and CORDIC set-up, one CORDIC
// rotation per cycle, wrap, then rounding and output load. The block then
// returns to idle, where the next request is accepted. The result sits in an
// output register, so a new request is taken once the result is loaded and
// the block is idle, even if the sink has not yet taken it; a result still
// waiting at the end of the next request holds that request in its final
// state until the sink takes it.
module magnetometer_hard_iron_heading import mhh_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_W-1:0]      i_cfg_data,
    mhh_in_if.sink               i_in,
    mhh_out_if.source            o_out
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_UPD, S_CORR, S_INIT, S_CORD, S_WRAP, S_FIN
    } t_state;

    t_state                     r_state;
    logic [CFG_W-1:0]           r_gain_idx;
    logic [GAIN_W-1:0]          r_gsh;
    logic [MCNT_W-1:0]          r_mcnt;
    logic signed [RAW_W:0]      r_a [3];
    logic signed [SUM_W-1:0]    r_acc [3];
    logic signed [FIELD_W-1:0]  r_max [3];
    logic signed [FIELD_W-1:0]  r_min [3];
    logic signed [SUM_W-1:0]    r_f [3];
    logic signed [WIDE_W-1:0]   r_x;
    logic signed [WIDE_W-1:0]   r_y;
    logic signed [ANG_W-1:0]    r_z;
    logic [STEP_W-1:0]          r_step;
    logic                       r_zero;
    logic                       r_out_valid;
    logic signed [FIELD_W-1:0]  r_fx;
    logic signed [FIELD_W-1:0]  r_fy;
    logic signed [FIELD_W-1:0]  r_fz;
    logic [HEAD_W-1:0]          r_hd;

    logic                       in_take;
    logic                       out_free;
    logic signed [SUM_W-1:0]    n_acc [3];
    logic signed [SUM_W-1:0]    n_f [3];
    logic signed [WIDE_W-1:0]   sh_x;
    logic signed [WIDE_W-1:0]   sh_y;
    logic signed [ANG_W-1:0]    rnd_sum;
    logic [HEAD_W+1:0]          n_hd;

    assign i_in.ready    = (r_state == S_IDLE);
    assign in_take       = i_in.valid && i_in.ready;
    assign out_free      = !r_out_valid || o_out.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.field_x = r_fx;
    assign o_out.field_y = r_fy;
    assign o_out.field_z = r_fz;
    assign o_out.heading = r_hd;

    // Serial multiply step, midpoint subtraction per axis.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_acc[k] = (r_acc[k] <<< 1)
                     + (r_gsh[GAIN_W-1] ? SUM_W'(r_a[k]) : SUM_W'(0));
            n_f[k]   = r_f[k]
                     - SUM_W'((SUM_W'(r_max[k]) + SUM_W'(r_min[k])) >>> 1);
        end
    end

    // CORDIC shifts and final rounding.
    assign sh_x    = r_x >>> r_step;
    assign sh_y    = r_y >>> r_step;
    assign rnd_sum = (r_z + ANG_RND) >>> ANG_FRAC;
    assign n_hd    = rnd_sum[HEAD_W+1:0];

    // Sequencer, datapath registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain_idx  <= GAIN_RESET;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_max[k] <= -RESET_EXTREME;
                r_min[k] <= RESET_EXTREME;
            end
        end else begin
            if (i_cfg_we) begin
                r_gain_idx <= i_cfg_data;
            end
            // The output register is loaded at the end of a request and cleared when taken.
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_a[0]  <= -(RAW_W+1)'(i_in.raw_x);
                        r_a[1]  <= (RAW_W+1)'(i_in.raw_y);
                        r_a[2]  <= (RAW_W+1)'(i_in.raw_z);
                        r_gsh   <= gain_q8(r_gain_idx);
                        r_mcnt  <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_acc[k] <= '0;
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    for (int k = 0; k < 3; k++) begin
                        r_acc[k] <= n_acc[k];
                    end
                    r_gsh  <= r_gsh << 1;
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == MCNT_W'(GAIN_W - 1)) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    // Products fit the field width exactly.
                    for (int k = 0; k < 3; k++) begin
                        r_f[k] <= r_acc[k];
                        if ($signed(r_acc[k][FIELD_W-1:0]) > r_max[k]) begin
                            r_max[k] <= r_acc[k][FIELD_W-1:0];
                        end
                        if ($signed(r_acc[k][FIELD_W-1:0]) < r_min[k]) begin
                            r_min[k] <= r_acc[k][FIELD_W-1:0];
                        end
                    end
                    r_state <= S_CORR;
                end
                S_CORR: begin
                    for (int k = 0; k < 3; k++) begin
                        r_f[k] <= n_f[k];
                    end
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    // Left half plane starts turned by half a circle.
                    r_zero <= (r_f[0] == '0) && (r_f[1] == '0);
                    r_step <= '0;
                    if (r_f[1] < 0) begin
                        r_x <= -WIDE_W'(r_f[1]);
                        r_y <= -WIDE_W'(r_f[0]);
                        r_z <= ANG_HALF;
                    end else begin
                        r_x <= WIDE_W'(r_f[1]);
                        r_y <= WIDE_W'(r_f[0]);
                        r_z <= '0;
                    end
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (r_y > 0) begin
                        r_x <= r_x + sh_y;
                        r_y <= r_y - sh_x;
                        r_z <= r_z + atan_tab(r_step);
                    end else begin
                        r_x <= r_x - sh_y;
                        r_y <= r_y + sh_x;
                        r_z <= r_z - atan_tab(r_step);
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(RUN_STEPS - 1)) begin
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if (r_z < 0) begin
                        r_z <= r_z + ANG_FULL;
                    end else if (r_z >= ANG_FULL) begin
                        r_z <= r_z - ANG_FULL;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_fx        <= r_f[0][FIELD_W-1:0];
                        r_fy        <= r_f[1][FIELD_W-1:0];
                        r_fz        <= r_f[2][FIELD_W-1:0];
                        if (r_zero || n_hd >= HEAD_FULL) begin
                            r_hd <= '0;
                        end else begin
                            r_hd <= n_hd[HEAD_W-1:0];
                        end
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks on sequencing and result range.
    `MHH_ASSERT_NEXT(a_take_starts_mul, i_clk, i_rst_n, in_take, r_state == S_MUL)
    `MHH_ASSERT_NOW(a_heading_range, i_clk, i_rst_n, r_out_valid, r_hd < HEAD_FULL[HEAD_W-1:0])
    `MHH_ASSERT_NOW(a_step_bound, i_clk, i_rst_n, r_state == S_CORD, r_step < STEP_W'(RUN_STEPS))
    `MHH_ASSERT_NEXT(a_fin_loads, i_clk, i_rst_n, r_state == S_FIN && out_free, r_out_valid)

endmodule
`default_nettype wire
